### hdl/tdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the table-driven CRC.
// No dependencies; compile first.
package tdc_pkg;

    // Fixed field widths of the ports
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_WIDTH_W   = 7;
    localparam int BYTE_W        = 8;
    localparam int CRC_OUT_W     = 64;

    // Table geometry and defaults
    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_ADDR_W  = 8;
    localparam int DEF_MAX_CRC_WIDTH = 64;

    // Reset values of the configuration registers
    localparam logic [CFG_WIDTH_W-1:0] RST_CRC_WIDTH = 7'd32;
    localparam logic [CFG_DATA_W-1:0]  RST_POLYNOMIAL = 64'h0000_0000_04C1_1DB7;
    localparam logic [CFG_DATA_W-1:0]  RST_INIT_VALUE = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0]  RST_FINAL_XOR  = 64'h0000_0000_FFFF_FFFF;
    localparam logic                   RST_REFLECT_IN  = 1'b1;
    localparam logic                   RST_REFLECT_OUT = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CRC_WIDTH   = 3'd0,
        REG_POLYNOMIAL  = 3'd1,
        REG_INIT_VALUE  = 3'd2,
        REG_FINAL_XOR   = 3'd3,
        REG_REFLECT_IN  = 3'd4,
        REG_REFLECT_OUT = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        ST_BUILD = 1'b0,
        ST_RUN   = 1'b1
    } t_tbl_state;

    function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

### hdl/tdc_if.sv
`timescale 1ns / 1ps
// Handshake channels of the table-driven CRC: byte input, CRC output, config writes.
// Depends on tdc_pkg.
interface tdc_byte_if
    import tdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface tdc_crc_if
    import tdc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CRC_OUT_W-1:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

interface tdc_cfg_if
    import tdc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/table_driven_crc.sv
`timescale 1ns / 1ps
// Top level of the byte-wise table-driven CRC: table memory, build sequencer,
// CRC feedback loop and result register. Depends on tdc_pkg and tdc_if.

// Byte-wise CRC of configurable width (8 to MAX_CRC_WIDTH bits), polynomial,
// initial value, final XOR and input/output reflection. A 256-entry lookup
// table held in a synchronous single-port memory is built after reset and
// after every write of the width or the polynomial register; no data word
// is accepted during the build (config writes are always taken). Once
// built, the block takes a new byte only after the previous one is folded
// in and its result has left the CRC register: the table address depends
// on the CRC left by the previous byte and the memory read is registered.
// A result word moves from the CRC register into the output register once
// that register is free; one result may wait there while the next byte is
// already being folded in. Every byte yields one result word, zero above
// the CRC width. Write configuration only while no byte is in flight.
module table_driven_crc
    import tdc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = DEF_MAX_CRC_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tdc_cfg_if.sink    i_cfg,
    tdc_byte_if.sink   i_byte,
    tdc_crc_if.source  o_crc
);

    localparam int DW = MAX_CRC_WIDTH;
    localparam int WW = $clog2(DW + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0] r_width;
    logic [DW-1:0]          r_poly;
    logic [DW-1:0]          r_init;
    logic [DW-1:0]          r_fxor;
    logic                   r_refl_in;
    logic                   r_refl_out;

    logic cfg_wr;
    logic rebuild;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_CRC_WIDTH;
            r_poly     <= DW'(RST_POLYNOMIAL);
            r_init     <= DW'(RST_INIT_VALUE);
            r_fxor     <= DW'(RST_FINAL_XOR);
            r_refl_in  <= RST_REFLECT_IN;
            r_refl_out <= RST_REFLECT_OUT;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_CRC_WIDTH:   r_width    <= i_cfg.data[CFG_WIDTH_W-1:0];
                REG_POLYNOMIAL:  r_poly     <= i_cfg.data[DW-1:0];
                REG_INIT_VALUE:  r_init     <= i_cfg.data[DW-1:0];
                REG_FINAL_XOR:   r_fxor     <= i_cfg.data[DW-1:0];
                REG_REFLECT_IN:  r_refl_in  <= i_cfg.data[0];
                REG_REFLECT_OUT: r_refl_out <= i_cfg.data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // a width or polynomial write invalidates the table
    assign rebuild = cfg_wr &&
                     (i_cfg.index == REG_CRC_WIDTH || i_cfg.index == REG_POLYNOMIAL);

    // ------------------------------------------------------------------
    // Effective width and derived masks
    // ------------------------------------------------------------------
    logic [WW-1:0] w_eff;
    logic [WW-1:0] top_sh;    // w - 8: position of the top byte
    logic [WW-1:0] pad_sh;    // DW - w: unused bits above the CRC
    logic [DW-1:0] mask;
    logic [DW-1:0] top_bit;
    logic [DW-1:0] poly_m;

    always_comb begin
        if (r_width < CFG_WIDTH_W'(8)) begin
            w_eff = WW'(8);
        end else if (r_width > CFG_WIDTH_W'(DW)) begin
            w_eff = WW'(DW);
        end else begin
            w_eff = WW'(r_width);
        end
        top_sh  = w_eff - WW'(8);
        pad_sh  = WW'(DW) - w_eff;
        mask    = {DW{1'b1}} >> pad_sh;
        top_bit = mask ^ (mask >> 1);
        poly_m  = r_poly & mask;
    end

    // four MSB-first shift-and-XOR steps of the table build
    function automatic logic [DW-1:0] step4(
        input logic [DW-1:0] acc_in,
        input logic [DW-1:0] poly,
        input logic [DW-1:0] msk,
        input logic [DW-1:0] top
    );
        logic [DW-1:0] acc;
        acc = acc_in;
        for (int s = 0; s < 4; s++) begin
            if (|(acc & top)) begin
                acc = ((acc << 1) ^ poly) & msk;
            end else begin
                acc = (acc << 1) & msk;
            end
        end
        return acc;
    endfunction

    // ------------------------------------------------------------------
    // Table build sequencer
    // ------------------------------------------------------------------
    t_tbl_state                r_state;
    t_tbl_state                n_state;
    logic [TABLE_ADDR_W-1:0]   r_bidx;
    logic                      r_bhalf;   // 0: first four steps, 1: last four and write
    logic [DW-1:0]             r_bacc;
    logic                      build_active;
    logic                      tbl_wr;
    logic                      build_last;

    assign build_last = r_bhalf && (r_bidx == TABLE_ADDR_W'(TABLE_ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_BUILD: begin
                if (!rebuild && build_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (rebuild) begin
                    n_state = ST_BUILD;
                end
            end
            default: n_state = ST_BUILD;
        endcase
    end

    always_comb begin
        build_active = 1'b0;
        tbl_wr       = 1'b0;
        unique case (r_state)
            ST_BUILD: begin
                build_active = 1'b1;
                tbl_wr       = r_bhalf;
            end
            ST_RUN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BUILD;
            r_bidx  <= '0;
            r_bhalf <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rebuild) begin
                r_bidx  <= '0;
                r_bhalf <= 1'b0;
            end else if (build_active) begin
                r_bhalf <= ~r_bhalf;
                if (r_bhalf) begin
                    r_bidx <= r_bidx + TABLE_ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (build_active && !r_bhalf) begin
            r_bacc <= step4(DW'(r_bidx) << top_sh, poly_m, mask, top_bit);
        end
    end

    // ------------------------------------------------------------------
    // Handshake control of the CRC loop
    // ------------------------------------------------------------------
    logic r_pend;       // table read in flight, CRC update next cycle
    logic r_fin_pend;   // r_crc holds a result not yet moved to the output
    logic r_out_valid;
    logic fin_go;
    logic in_acc;

    assign fin_go       = r_fin_pend && (!r_out_valid || o_crc.ready);
    assign i_byte.ready = !build_active && !r_pend && (!r_fin_pend || fin_go);
    assign in_acc       = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_fin_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= in_acc;
            if (r_pend) begin
                r_fin_pend <= 1'b1;
            end else if (fin_go) begin
                r_fin_pend <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_crc.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: restart, mask, form table address
    // ------------------------------------------------------------------
    logic [DW-1:0]           r_crc;
    logic [DW-1:0]           r_shift;   // (crc << 8) waiting for the table word
    logic [DW-1:0]           crc_cur;
    logic [BYTE_W-1:0]       byte_in;
    logic [TABLE_ADDR_W-1:0] rd_addr;

    always_comb begin
        crc_cur = (i_byte.restart ? r_init : r_crc) & mask;
        byte_in = r_refl_in ? reverse_byte(i_byte.data_byte) : i_byte.data_byte;
        rd_addr = TABLE_ADDR_W'(crc_cur >> top_sh) ^ byte_in;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_shift <= (crc_cur << BYTE_W) & mask;
        end
    end

    // ------------------------------------------------------------------
    // Lookup table memory: written by the build, read by the accept stage
    // ------------------------------------------------------------------
    logic [DW-1:0] r_table [TABLE_ENTRIES];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_table[r_bidx] <= step4(r_bacc, poly_m, mask, top_bit);
        end
        if (in_acc) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Fold stage: update the CRC register with the table word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= DW'(RST_INIT_VALUE);
        end else if (r_pend) begin
            r_crc <= r_shift ^ r_rd_data;
        end
    end

    // ------------------------------------------------------------------
    // Result stage: final XOR, optional reflection over the CRC width
    // ------------------------------------------------------------------
    logic [DW-1:0] res_x;
    logic [DW-1:0] res_rev;
    logic [DW-1:0] res_fin;
    logic [DW-1:0] r_out_data;

    always_comb begin
        res_x = (r_crc ^ r_fxor) & mask;
        for (int i = 0; i < DW; i++) begin
            res_rev[i] = res_x[DW-1-i];
        end
        res_fin = r_refl_out ? (res_rev >> pad_sh) : res_x;
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_data <= res_fin;
        end
    end

    assign o_crc.valid     = r_out_valid;
    assign o_crc.crc_value = CRC_OUT_W'(r_out_data);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // no byte may be folded in while the table is incomplete
    a_no_accept_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == ST_RUN))
        else $error("byte accepted during table build");

    // the CRC loop interlock: an accepted byte blocks the next cycle
    a_loop_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_byte.ready)
        else $error("byte accepted while table read in flight");

    // every fold produces a pending result the cycle after
    a_fold_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_fin_pend)
        else $error("folded CRC lost before result stage");

    // a pending result must not be overwritten by the next fold
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_fin_pend) |-> fin_go)
        else $error("CRC register overwritten before result taken");

endmodule
